/* rtl/core/mscq_pkg.sv */
`timescale 1ns / 1ps

package mscq_pkg;

	// width of a state value, fixed by the sample and result fields
	localparam int STATE_BITS = 16;
	localparam int CHAN_BITS  = 4;
	localparam int TICK_BITS  = 32;
	localparam int CNT_BITS   = 32;
	localparam int REP_BITS   = 8;

	// register map, word index taken from paddr[3:2]
	localparam int APB_ADDR_BITS = 4;
	typedef enum logic [1:0] {
		REG_HYSTERESIS = 2'd0,
		REG_INTERVAL   = 2'd1,
		REG_ACTION_EN  = 2'd2
	} reg_idx_t;

	localparam logic [REP_BITS-1:0] REP_MAX = '1;

	typedef struct packed {
		logic [CHAN_BITS-1:0]  channel;
		logic [TICK_BITS-1:0]  now;
		logic [STATE_BITS-1:0] sample_state;
	} in_req_t;

	typedef struct packed {
		logic [CHAN_BITS-1:0]  out_channel;
		logic                  checked;
		logic                  action_fired;
		logic [STATE_BITS-1:0] prior_state;
		logic [STATE_BITS-1:0] accepted_state;
		logic [CNT_BITS-1:0]   check_total;
		logic [CNT_BITS-1:0]   action_total;
	} out_rsp_t;

	typedef struct packed {
		logic [REP_BITS-1:0] hysteresis_count;
		logic [15:0]         interval_ticks;
		logic                action_enabled;
	} cfg_t;

	// one channel entry of the state memory
	typedef struct packed {
		logic [STATE_BITS-1:0] reference_state;
		logic [STATE_BITS-1:0] candidate_value;
		logic [REP_BITS-1:0]   repeat_count;
		logic [TICK_BITS-1:0]  last_check_tick;
		logic [CNT_BITS-1:0]   checks_done;
		logic [CNT_BITS-1:0]   actions_done;
	} chan_entry_t;

endpackage

/* rtl/core/mscq_cfg.sv */
`timescale 1ns / 1ps

module mscq_cfg import mscq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	output cfg_t                     cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;
	assign cfg     = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hysteresis_count <= '0;
			cfg_q.interval_ticks   <= 16'd1;
			cfg_q.action_enabled   <= 1'b1;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_HYSTERESIS: cfg_q.hysteresis_count <= pwdata[REP_BITS-1:0];
				REG_INTERVAL:   cfg_q.interval_ticks   <= pwdata[15:0];
				REG_ACTION_EN:  cfg_q.action_enabled   <= pwdata[0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_HYSTERESIS: prdata = {{(32-REP_BITS){1'b0}}, cfg_q.hysteresis_count};
			REG_INTERVAL:   prdata = {16'b0, cfg_q.interval_ticks};
			REG_ACTION_EN:  prdata = {31'b0, cfg_q.action_enabled};
			default:        prdata = '0;
		endcase
	end

endmodule

/* rtl/core/mscq_chan_mem.sv */
`timescale 1ns / 1ps

module mscq_chan_mem import mscq_pkg::*; #(
	parameter int CHANNELS = 16,
	parameter int IW       = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [IW-1:0] rd_idx,
	input  logic          wr_en,
	input  logic [IW-1:0] wr_idx,
	input  chan_entry_t   wr_data,
	output chan_entry_t   rd_data
);

	chan_entry_t         mem [CHANNELS];
	logic [CHANNELS-1:0] vld_q;
	chan_entry_t         rd_q;
	chan_entry_t         fwd_q;
	logic                rd_vld_q;
	logic                fwd_hit_q;

	// entry array, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
			fwd_q       <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_idx];
		end
	end

	// per-entry valid bits so a fresh entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_q  <= 1'b0;
			fwd_hit_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q  <= vld_q[rd_idx];
				// a write to the same entry on the read edge is not seen by the array read
				fwd_hit_q <= wr_en && (wr_idx == rd_idx);
			end
		end
	end

	// resolve forwarded, stored or reset value
	always_comb begin
		if (fwd_hit_q) begin
			rd_data = fwd_q;
		end else if (rd_vld_q) begin
			rd_data = rd_q;
		end else begin
			rd_data = '0;
		end
	end

endmodule

/* rtl/core/mscq_update.sv */
`timescale 1ns / 1ps

module mscq_update import mscq_pkg::*; (
	input  cfg_t                  cfg,
	input  chan_entry_t           cur,
	input  logic                  in_range,
	input  logic [CHAN_BITS-1:0]  channel,
	input  logic [TICK_BITS-1:0]  now,
	input  logic [STATE_BITS-1:0] sample,
	output chan_entry_t           nxt,
	output logic                  wr_en,
	output out_rsp_t              rsp
);

	logic [TICK_BITS-1:0] due;
	logic [TICK_BITS-1:0] diff;
	logic                 checked;
	logic                 qualified;
	logic                 fire;
	logic [REP_BITS-1:0]  rep_inc;

	// wrap-safe interval test
	assign due     = cur.last_check_tick + {16'b0, cfg.interval_ticks};
	assign diff    = due - now;
	assign checked = in_range && diff[TICK_BITS-1];
	assign rep_inc = (cur.repeat_count != REP_MAX) ? cur.repeat_count + REP_BITS'(1)
		: cur.repeat_count;
	assign wr_en   = checked;

	// hysteresis qualification and entry update
	always_comb begin
		nxt       = cur;
		qualified = 1'b0;
		if (cfg.hysteresis_count == '0) begin
			qualified = (cur.reference_state != sample);
		end else if (cur.reference_state == sample) begin
			nxt.repeat_count    = '0;
			nxt.candidate_value = sample;
		end else if (cur.candidate_value == sample) begin
			if (rep_inc >= cfg.hysteresis_count) begin
				nxt.repeat_count = '0;
				qualified        = 1'b1;
			end else begin
				nxt.repeat_count = rep_inc;
			end
		end else begin
			nxt.candidate_value = sample;
			nxt.repeat_count    = REP_BITS'(1);
		end
		fire = qualified && cfg.action_enabled;
		if (fire) begin
			nxt.reference_state = sample;
			nxt.actions_done    = cur.actions_done + CNT_BITS'(1);
		end
		nxt.checks_done     = cur.checks_done + CNT_BITS'(1);
		nxt.last_check_tick = now;
	end

	// result fields
	always_comb begin
		rsp              = '0;
		rsp.out_channel  = channel;
		rsp.checked      = checked;
		rsp.action_fired = checked && fire;
		if (in_range) begin
			rsp.prior_state = cur.reference_state;
			if (checked) begin
				rsp.accepted_state = nxt.reference_state;
				rsp.check_total    = nxt.checks_done;
				rsp.action_total   = nxt.actions_done;
			end else begin
				rsp.accepted_state = cur.reference_state;
				rsp.check_total    = cur.checks_done;
				rsp.action_total   = cur.actions_done;
			end
		end
	end

endmodule

/* rtl/core/multichannel_state_change_qualifier.sv */
`timescale 1ns / 1ps

// Per-channel state-change qualifier (consecutive-count debouncer). Each request
// names a channel, the current tick and a sampled value; a request whose
// channel interval has elapsed is evaluated against the channel's reference
// state and counts toward the shared hysteresis threshold, and every request
// returns exactly one result. Channel state lives in one memory with a registered
// read: a request is read on acceptance, then updated, written back and its
// result loaded into the output register as it leaves stage 1. One request is
// taken every cycle while the output is not stalled; back-to-back requests to
// the same channel are served by forwarding the write-back, so no bubbles are
// inserted. Entries read as zero after reset through per-entry valid bits, so
// no clearing pass is needed. Shared settings (hysteresis count, interval
// ticks, action enable) sit on the APB port at byte addresses 0, 4 and 8; the
// user must write them only while idle, as the block does not enforce this.
module multichannel_state_change_qualifier import mscq_pkg::*; #(
	parameter int CHANNELS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  in_req_t                  in_req,
	output logic                     out_valid,
	input  logic                     out_stall,
	output out_rsp_t                 out_rsp,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);

	localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	cfg_t                  cfg;
	logic                  accept;
	logic                  s1_adv;
	logic                  valid_s1;
	logic                  in_range_s1;
	logic [CHAN_BITS-1:0]  channel_s1;
	logic [TICK_BITS-1:0]  now_s1;
	logic [STATE_BITS-1:0] sample_s1;
	chan_entry_t           cur_entry;
	chan_entry_t           nxt_entry;
	logic                  upd_wr;
	logic                  mem_wr;
	out_rsp_t              rsp_s1;
	logic                  out_valid_q;
	out_rsp_t              out_rsp_q;

	// pipeline flow
	assign s1_adv    = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !s1_adv;
	assign accept    = in_valid && !in_stall;
	assign mem_wr    = s1_adv && upd_wr;
	assign out_valid = out_valid_q;
	assign out_rsp   = out_rsp_q;

	mscq_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mscq_chan_mem #(
		.CHANNELS (CHANNELS),
		.IW       (IW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_idx  (IW'(in_req.channel)),
		.wr_en   (mem_wr),
		.wr_idx  (IW'(channel_s1)),
		.wr_data (nxt_entry),
		.rd_data (cur_entry)
	);

	mscq_update u_update (
		.cfg      (cfg),
		.cur      (cur_entry),
		.in_range (in_range_s1),
		.channel  (channel_s1),
		.now      (now_s1),
		.sample   (sample_s1),
		.nxt      (nxt_entry),
		.wr_en    (upd_wr),
		.rsp      (rsp_s1)
	);

	// stage 1 request payload and output result register
	always_ff @(posedge clk) begin
		if (accept) begin
			channel_s1  <= in_req.channel;
			now_s1      <= in_req.now;
			sample_s1   <= in_req.sample_state;
			in_range_s1 <= (32'(in_req.channel) < 32'(CHANNELS));
		end
		if (s1_adv) begin
			out_rsp_q <= rsp_s1;
		end
	end

	// stage 1 and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// memory is written only by a request leaving stage 1
	a_wr_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr |-> valid_s1 && in_range_s1)
		else $error("state write without a request in stage 1");

	// stage 1 never overwrites a held result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |-> !(out_valid_q && out_stall))
		else $error("result register overwritten while stalled");

	// a fired action always changes the reference state
	a_fire_changes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_rsp_q.action_fired |->
			out_rsp_q.checked && (out_rsp_q.prior_state != out_rsp_q.accepted_state))
		else $error("action fired without a state change");

	// an unevaluated sample leaves the reference state alone
	a_unchecked_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_rsp_q.checked |->
			!out_rsp_q.action_fired && (out_rsp_q.prior_state == out_rsp_q.accepted_state))
		else $error("reference state changed without a check");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench import mscq_pkg::*;;

	localparam int NCHAN = 1 << CHAN_BITS;

	// expected-result store and per-channel debounce predictor
	class qualifier_scoreboard;
		logic [REP_BITS-1:0]   hysteresis;
		logic [15:0]           interval;
		logic                  action_en;
		logic [STATE_BITS-1:0] ref_state [NCHAN];
		logic [STATE_BITS-1:0] candidate [NCHAN];
		logic [REP_BITS-1:0]   repeats [NCHAN];
		logic [TICK_BITS-1:0]  last_tick [NCHAN];
		logic [CNT_BITS-1:0]   checks [NCHAN];
		logic [CNT_BITS-1:0]   actions [NCHAN];
		out_rsp_t              pending_results [$];
		int unsigned           mismatches;

		function new();
			hysteresis = '0;
			interval   = 16'd1;
			action_en  = 1'b1;
			mismatches = 0;
			for (int i = 0; i < NCHAN; i++) begin
				ref_state[i] = '0;
				candidate[i] = '0;
				repeats[i]   = '0;
				last_tick[i] = '0;
				checks[i]    = '0;
				actions[i]   = '0;
			end
		endfunction

		function void write_reg(reg_idx_t idx, logic [31:0] value);
			case (idx)
				REG_HYSTERESIS: hysteresis = value[REP_BITS-1:0];
				REG_INTERVAL:   interval = value[15:0];
				REG_ACTION_EN:  action_en = value[0];
				default: ;
			endcase
		endfunction

		function void flag_error(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("[%0t] %s", $realtime, msg);
		endfunction

		// consecutive-repeat test; updates candidate and repeat count
		function bit change_qualifies(int ch, logic [STATE_BITS-1:0] s);
			if (hysteresis == '0)
				return ref_state[ch] != s;
			if (ref_state[ch] == s) begin
				repeats[ch] = '0;
				candidate[ch] = s;
				return 1'b0;
			end
			if (candidate[ch] == s) begin
				if (repeats[ch] != REP_MAX)
					repeats[ch]++;
				if (repeats[ch] >= hysteresis) begin
					repeats[ch] = '0;
					return 1'b1;
				end
			end else begin
				candidate[ch] = s;
				repeats[ch] = REP_BITS'(1);
			end
			return 1'b0;
		endfunction

		function void note_request(in_req_t r);
			int ch;
			logic [31:0] diff;
			out_rsp_t e;
			ch = int'(r.channel);
			e = '0;
			e.out_channel = r.channel;
			e.prior_state = ref_state[ch];
			// wrap-safe: sampled when now lies after last check plus interval
			diff = last_tick[ch] + {16'd0, interval} - r.now;
			if (diff[31]) begin
				e.checked = 1'b1;
				checks[ch]++;
				if (change_qualifies(ch, r.sample_state) && action_en) begin
					e.action_fired = 1'b1;
					ref_state[ch] = r.sample_state;
					actions[ch]++;
				end
				last_tick[ch] = r.now;
			end
			e.accepted_state = ref_state[ch];
			e.check_total = checks[ch];
			e.action_total = actions[ch];
			pending_results.push_back(e);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got)
				flag_error($sformatf("%s: expected %h, got %h", name, want, got));
		endfunction

		function void check_result(out_rsp_t got);
			out_rsp_t want;
			if (pending_results.size() == 0) begin
				flag_error($sformatf("result with no request outstanding: %h", got));
				return;
			end
			want = pending_results.pop_front();
			compare_field("out_channel", 32'(want.out_channel), 32'(got.out_channel));
			compare_field("checked", 32'(want.checked), 32'(got.checked));
			compare_field("action_fired", 32'(want.action_fired), 32'(got.action_fired));
			compare_field("prior_state", 32'(want.prior_state), 32'(got.prior_state));
			compare_field("accepted_state", 32'(want.accepted_state),
				32'(got.accepted_state));
			compare_field("check_total", want.check_total, got.check_total);
			compare_field("action_total", want.action_total, got.action_total);
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	in_req_t                  in_req = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	out_rsp_t                 out_rsp;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [APB_ADDR_BITS-1:0] paddr = '0;
	logic [31:0]              pwdata = '0;
	logic [31:0]              prdata;
	logic                     pready;

	qualifier_scoreboard board = new();

	logic [31:0]           tick = '0;
	logic [STATE_BITS-1:0] last_sent [NCHAN];
	bit                    send_idle_en = 1'b1;
	bit                    recv_idle_en = 1'b1;

	multichannel_state_change_qualifier dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_req(in_req),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_rsp(out_rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #10 clk = ~clk;

	// setup then access phase, register taken when pready is seen
	task automatic apb_write(reg_idx_t idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		board.write_reg(idx, value);
		// bus idle between transfers
		@(posedge clk);
	endtask

	// one request with a random lead-in gap
	task automatic send_request(logic [3:0] ch, logic [31:0] now, logic [15:0] s);
		int unsigned gap;
		in_req_t r;
		gap = send_idle_en ? $urandom_range(0, 19) : 0;
		r.channel = ch;
		r.now = now;
		r.sample_state = s;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_req <= r;
		do @(posedge clk); while (in_stall !== 1'b0);
		board.note_request(r);
	endtask

	// hold off the sender until every expected result is back
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (board.pending_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(int unsigned hyst, int unsigned intv, int unsigned act,
		int unsigned nch, int unsigned items, int unsigned stick,
		int unsigned noise, int unsigned step_min);
		logic [15:0] pool [4];
		logic [3:0] base;
		logic [3:0] ch;
		logic [31:0] now;
		logic [15:0] s;
		int unsigned step_max;
		apb_write(REG_HYSTERESIS, hyst);
		apb_write(REG_INTERVAL, intv);
		apb_write(REG_ACTION_EN, act);
		pool[0] = 16'h0000;
		pool[1] = 16'hFFFF;
		pool[2] = 16'($urandom);
		pool[3] = 16'($urandom);
		base = 4'($urandom);
		// tick steps sized so per-channel spacing straddles the interval
		step_max = (2 * intv) / nch + 1;
		if (step_max < step_min)
			step_max = step_min;
		repeat (items) begin
			ch = base + 4'($urandom_range(0, nch - 1));
			if ($urandom_range(0, 999) < stick)
				s = last_sent[ch];
			else if ($urandom_range(0, 3) != 0)
				s = pool[$urandom_range(0, 3)];
			else
				s = 16'($urandom);
			last_sent[ch] = s;
			if ($urandom_range(0, 999) < noise) begin
				now = $urandom;
			end else if ($urandom_range(0, 999) < noise) begin
				now = tick - $urandom_range(0, 100);
			end else begin
				tick = tick + $urandom_range(step_min, step_max);
				now = tick;
			end
			send_request(ch, now, s);
			if ($urandom_range(0, 99) == 0)
				drain_results();
		end
		drain_results();
	endtask

	// result side: random stall before each result
	initial begin
		int unsigned hold;
		wait (arst_n === 1'b1);
		forever begin
			hold = recv_idle_en ? $urandom_range(0, 19) : 0;
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			board.check_result(out_rsp);
		end
	end

	initial begin
		int unsigned hyst, intv, act, nch, items, stick, noise, step_min;
		for (int i = 0; i < NCHAN; i++)
			last_sent[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: immediate accept, interval one tick
		send_request(4'd0, 32'd0, 16'hFFFF);
		send_request(4'd0, 32'd1, 16'hFFFF);
		send_request(4'd0, 32'd2, 16'hFFFF);
		send_request(4'd0, 32'd4, 16'hFFFF);
		// tick just behind zero, then half a wrap ahead
		send_request(4'd15, 32'hFFFF_FFFF, 16'h0000);
		send_request(4'd15, 32'h8000_0001, 16'h0000);
		send_request(4'd15, 32'h8000_0003, 16'hA5A5);
		drain_results();

		// qualified change while the action is disabled
		apb_write(REG_HYSTERESIS, 32'd3);
		apb_write(REG_ACTION_EN, 32'd0);
		send_request(4'd1, 32'd10, 16'h5A5A);
		send_request(4'd1, 32'd12, 16'h5A5A);
		send_request(4'd1, 32'd14, 16'h5A5A);
		send_request(4'd1, 32'd16, 16'h0000);
		drain_results();

		// hysteresis lowered below a running count
		apb_write(REG_ACTION_EN, 32'd1);
		apb_write(REG_HYSTERESIS, 32'd5);
		send_request(4'd2, 32'd20, 16'h0F0F);
		send_request(4'd2, 32'd22, 16'h0F0F);
		send_request(4'd2, 32'd24, 16'h0F0F);
		send_request(4'd2, 32'd26, 16'h0F0F);
		drain_results();
		apb_write(REG_HYSTERESIS, 32'd2);
		send_request(4'd2, 32'd28, 16'h0F0F);
		send_request(4'd2, 32'd30, 16'h1111);
		send_request(4'd2, 32'd32, 16'h2222);
		send_request(4'd2, 32'd34, 16'h2222);
		drain_results();

		// zero and widest interval
		apb_write(REG_HYSTERESIS, 32'd0);
		apb_write(REG_INTERVAL, 32'd0);
		send_request(4'd3, 32'd0, 16'h0001);
		send_request(4'd3, 32'd1, 16'h0001);
		drain_results();
		apb_write(REG_INTERVAL, 32'd65535);
		send_request(4'd3, 32'd65536, 16'h0002);
		send_request(4'd3, 32'd65537, 16'h0002);
		drain_results();

		// random phases, fixed extremes first
		for (int p = 0; p < 14; p++) begin
			items = 75;
			noise = 30;
			step_min = 0;
			send_idle_en = ($urandom_range(0, 3) != 0);
			recv_idle_en = ($urandom_range(0, 3) != 0);
			case (p)
				0: begin
					hyst = 0; intv = 0; act = 1; nch = 16; stick = 300;
					send_idle_en = 1'b0;
					recv_idle_en = 1'b0;
				end
				1: begin
					hyst = 1; intv = 1; act = 1; nch = 4; stick = 500;
				end
				2: begin
					hyst = 3; intv = 65535; act = 1; nch = 3; stick = 500;
					tick = 32'hFFFF_0000;
				end
				3: begin
					// full 255 repeats on one channel, every sample checked
					hyst = 255; intv = 0; act = 1; nch = 1; stick = 1000;
					items = 300; noise = 0; step_min = 1;
				end
				4: begin
					hyst = 2; intv = 3; act = 0; nch = 6; stick = 500;
				end
				5: begin
					hyst = 0; intv = 65535; act = 0; nch = 16; stick = 200;
				end
				default: begin
					hyst = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
						: $urandom_range(0, 9);
					case ($urandom_range(0, 3))
						0: intv = $urandom_range(0, 4);
						1: intv = $urandom_range(0, 300);
						2: intv = 65535;
						default: intv = $urandom_range(0, 65535);
					endcase
					act = $urandom_range(0, 1);
					nch = $urandom_range(1, 16);
					stick = $urandom_range(200, 900);
					if (p == 9)
						tick = 32'hFFFF_FF00;
				end
			endcase
			run_phase(hyst, intv, act, nch, items, stick, noise, step_min);
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (board.pending_results.size() != 0)
			board.flag_error("expected results left over at end of run");
		if (board.mismatches == 0) begin
			$display("multichannel_state_change_qualifier verification clean");
		end else begin
			$display("multichannel_state_change_qualifier verification failed");
		end
		$finish;
	end

	// run time limit
	initial begin
		#20_000_000;
		$display("multichannel_state_change_qualifier verification failed");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/mscq_pkg.sv
rtl/core/mscq_cfg.sv
rtl/core/mscq_chan_mem.sv
rtl/core/mscq_update.sv
rtl/core/multichannel_state_change_qualifier.sv
tb/testbench.sv
